### hw/rtl/smss_pkg.sv
// Shared types, sizes and codes for the sorted-matrix staircase search core.
// Depends on nothing; smss_walk and the top level import it.

package smss_pkg;

   localparam int MAX_ROWS   = 8;
   localparam int MAX_COLS   = 8;
   localparam int DATA_W     = 32;
   localparam int ROW_W      = 3;                        // width of a row field
   localparam int COL_W      = 3;                        // width of a column field
   localparam int ROW_CNT_W  = $clog2(MAX_ROWS + 1);     // holds 0..MAX_ROWS
   localparam int COL_CNT_W  = $clog2(MAX_COLS + 1);     // holds 0..MAX_COLS
   localparam int DEPTH      = MAX_ROWS * MAX_COLS;
   localparam int ADDR_W     = $clog2(DEPTH);
   localparam int CFG_W      = 4;
   localparam int CSR_ADDR_W = 1;

   typedef enum logic {
      CMD_WRITE  = 1'b0,
      CMD_SEARCH = 1'b1
   } cmd_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_ROWS = 1'b0,
      CSR_COLS = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_HOLD
   } state_type;

   // Finished search handed from the walker to the output register.
   typedef struct packed {
      logic             valid;
      logic             found;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
   } result_type;

   // Row-major entry address.
   function automatic logic [ADDR_W-1:0] entry_addr(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
      logic [31:0] a;
      a = 32'(row) * 32'(MAX_COLS) + 32'(col);
      return a[ADDR_W-1:0];
   endfunction

endpackage

### hw/rtl/smss_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.

module smss_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### hw/rtl/smss_walk.sv
// Command sequencer: entry writes and the staircase walk over the matrix RAM.
// Depends on smss_pkg; drives the ports of one smss_ram instance.

module smss_walk
   import smss_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   output logic                 ready,
   input  logic                 cmd,
   input  logic [ROW_W-1:0]     row_index,
   input  logic [COL_W-1:0]     col_index,
   input  logic [DATA_W-1:0]    data_value,
   input  logic [ROW_CNT_W-1:0] nrows,
   input  logic [COL_CNT_W-1:0] ncols,
   input  logic                 out_free,
   output result_type           result,
   output logic                 ram_we,
   output logic [ADDR_W-1:0]    ram_waddr,
   output logic [DATA_W-1:0]    ram_wdata,
   output logic [ADDR_W-1:0]    ram_raddr,
   input  logic [DATA_W-1:0]    ram_rdata
);

   state_type            state_ff, state_in;
   logic [ROW_CNT_W-1:0] row_ff, row_in;
   logic [COL_CNT_W-1:0] col_ff, col_in;
   logic [DATA_W-1:0]    key_ff, key_in;
   logic                 hit_ff, hit_in;
   logic [ROW_W-1:0]     res_row_ff, res_row_in;
   logic [COL_W-1:0]     res_col_ff, res_col_in;

   logic [ROW_CNT_W-1:0] row_next;
   logic [COL_CNT_W-1:0] col_next;
   logic [COL_CNT_W-1:0] col_cur_m1;
   logic [COL_CNT_W-1:0] col_next_m1;
   logic [COL_CNT_W-1:0] ncols_m1;
   logic                 in_range;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      row_ff     <= row_in;
      col_ff     <= col_in;
      key_ff     <= key_in;
      hit_ff     <= hit_in;
      res_row_ff <= res_row_in;
      res_col_ff <= res_col_in;
   end

   always_comb begin
      state_in   = state_ff;
      row_in     = row_ff;
      col_in     = col_ff;
      key_in     = key_ff;
      hit_in     = hit_ff;
      res_row_in = res_row_ff;
      res_col_in = res_col_ff;
      ready      = 1'b0;

      in_range    = (32'(row_index) < MAX_ROWS) && (32'(col_index) < MAX_COLS);
      ram_we      = 1'b0;
      ram_waddr   = entry_addr(row_index, col_index);
      ram_wdata   = data_value;

      ncols_m1    = ncols - COL_CNT_W'(1);
      col_cur_m1  = col_ff - COL_CNT_W'(1);
      row_next    = row_ff;
      col_next    = col_ff;
      // Move left when the entry is above the key, down when below.
      if ($signed(ram_rdata) > $signed(key_ff)) begin
         col_next = col_cur_m1;
      end else begin
         row_next = row_ff + ROW_CNT_W'(1);
      end
      col_next_m1 = col_next - COL_CNT_W'(1);
      ram_raddr   = entry_addr(ROW_W'(0), ncols_m1[COL_W-1:0]);

      case (state_ff)
         ST_IDLE: begin
            ready = 1'b1;
            if (accept) begin
               if (cmd == CMD_WRITE) begin
                  ram_we = in_range;
               end else begin
                  key_in     = data_value;
                  hit_in     = 1'b0;
                  res_row_in = '0;
                  res_col_in = '0;
                  row_in     = '0;
                  col_in     = ncols;
                  if (nrows == '0 || ncols == '0) begin
                     state_in = ST_HOLD;
                  end else begin
                     state_in = ST_WALK;
                  end
               end
            end
         end
         ST_WALK: begin
            if (ram_rdata == key_ff) begin
               hit_in     = 1'b1;
               res_row_in = row_ff[ROW_W-1:0];
               res_col_in = col_cur_m1[COL_W-1:0];
               state_in   = ST_HOLD;
            end else if (row_next == nrows || col_next == '0) begin
               state_in = ST_HOLD;
            end else begin
               row_in    = row_next;
               col_in    = col_next;
               ram_raddr = entry_addr(row_next[ROW_W-1:0], col_next_m1[COL_W-1:0]);
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      result.valid = (state_ff == ST_HOLD);
      result.found = hit_ff;
      result.row   = res_row_ff;
      result.col   = res_col_ff;
   end

endmodule

### hw/rtl/sorted_matrix_staircase_search_core.sv
// Top level of the sorted-matrix staircase search core: config registers,
// output register and the wiring of smss_walk to the matrix RAM (smss_ram).
// Depends on smss_pkg, smss_ram and smss_walk.
//
// Usage:
//   The req_ channel carries one word per command. tuser selects the command:
//   write stores data_value at (row_index, col_index); search looks for the
//   key data_value. A write gives no rsp_ word; every search gives exactly one.
//   The csr_ port sets rows_in_use (index 0) and cols_in_use (index 1); write
//   it only while no command is in flight.
//   Sequence: a write is stored in the RAM at its accept. A search goes through
//   its accept, then walk steps (each one RAM read plus compare, at most
//   rows_in_use + cols_in_use - 1 steps, so up to 15 for 8x8), then loads
//   the output register. Every walk step reads through the single RAM read
//   port; one command is handled at a time.
//   Reset: clears the sequencer and output valid, sets both size registers
//   to 8. Matrix contents are undefined until written.
//   Stall: a finished result sits in the output register; the next command is
//   accepted meanwhile, and a following search result waits in the sequencer
//   until the output register drains.

module sorted_matrix_staircase_search_core
   import smss_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // command words
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [39:0]           req_tdata,   // row_index[2:0], col_index[5:3],
                                              // data_value[37:6], zero pad[39:38]
   input  logic [0:0]            req_tuser,   // command[0]
   // result words
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,   // found_row[2:0], found_col[5:3],
                                              // zero pad[7:6]
   output logic [0:0]            rsp_tuser,   // found[0]
   // register writes
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CFG_W-1:0]      csr_wdata
);

   logic [CFG_W-1:0]     rows_ff, rows_in;
   logic [CFG_W-1:0]     cols_ff, cols_in;
   logic [ROW_CNT_W-1:0] nrows;
   logic [COL_CNT_W-1:0] ncols;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_found_ff, rsp_found_in;
   logic [ROW_W-1:0]     rsp_row_ff, rsp_row_in;
   logic [COL_W-1:0]     rsp_col_ff, rsp_col_in;

   logic                 accept;
   logic                 out_free;
   result_type           result;

   logic                 ram_we;
   logic [ADDR_W-1:0]    ram_waddr;
   logic [DATA_W-1:0]    ram_wdata;
   logic [ADDR_W-1:0]    ram_raddr;
   logic [DATA_W-1:0]    ram_rdata;

   // Size registers: values above the matrix size act as the full size.
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= CFG_W'(8);
         cols_ff <= CFG_W'(8);
      end else begin
         rows_ff <= rows_in;
         cols_ff <= cols_in;
      end
   end

   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_ROWS: rows_in = csr_wdata;
            CSR_COLS: cols_in = csr_wdata;
            default: begin
               rows_in = rows_ff;
            end
         endcase
      end
   end

   assign nrows = (32'(rows_ff) > MAX_ROWS) ? ROW_CNT_W'(MAX_ROWS) : ROW_CNT_W'(rows_ff);
   assign ncols = (32'(cols_ff) > MAX_COLS) ? COL_CNT_W'(MAX_COLS) : COL_CNT_W'(cols_ff);

   assign accept   = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;

   smss_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   smss_walk u_walk (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .ready      (req_tready),
      .cmd        (req_tuser[0]),
      .row_index  (req_tdata[2:0]),
      .col_index  (req_tdata[5:3]),
      .data_value (req_tdata[37:6]),
      .nrows      (nrows),
      .ncols      (ncols),
      .out_free   (out_free),
      .result     (result),
      .ram_we     (ram_we),
      .ram_waddr  (ram_waddr),
      .ram_wdata  (ram_wdata),
      .ram_raddr  (ram_raddr),
      .ram_rdata  (ram_rdata)
   );

   // Output register: load a finished search when the slot is free or drains.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_found_ff <= rsp_found_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_col_ff   <= rsp_col_in;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_found_in = rsp_found_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      if (result.valid && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_found_in = result.found;
         rsp_row_in   = result.row;
         rsp_col_in   = result.col;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_col_ff, rsp_row_ff};
   assign rsp_tuser  = rsp_found_ff;

endmodule
